>>> hdl/ibdw_pkg.sv
// Shared types and constants for the immersed-boundary delta weight block.
// No dependencies; the other files of the block import this package, except ibdw_sqrt.
package ibdw_pkg;

    // Default fraction width of coordinates, spacings and kernel values.
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths.
    localparam int COORD_W  = 32;
    localparam int INV_W    = 32;
    localparam int GAIN_W   = 32;
    localparam int WEIGHT_W = 48;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INV_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Z = 2'd2;

    // Reset value of each inverse spacing register, as an integer multiple of one.
    localparam int INV_RESET_INT = 20;

    // One input item: marker point and grid point.
    typedef struct packed {
        logic signed [COORD_W-1:0] cloud_x;
        logic signed [COORD_W-1:0] cloud_y;
        logic signed [COORD_W-1:0] cloud_z;
        logic signed [COORD_W-1:0] grid_x;
        logic signed [COORD_W-1:0] grid_y;
        logic signed [COORD_W-1:0] grid_z;
    } t_ibdw_in;

    // One result item.
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight_value;
        logic                saturated;
    } t_ibdw_out;

endpackage

>>> hdl/ibdw_sqrt.sv
// Pipelined floor integer square root, one result bit per register stage.
// Carries a sideband word alongside the radicand. Depends on nothing.
module ibdw_sqrt #(
    parameter int AW  = 34,
    parameter int SBW = 20
) (
    input  logic              i_clk,
    input  logic [AW-1:0]     i_arg,
    input  logic [SBW-1:0]    i_side,
    output logic [AW/2-1:0]   o_root,
    output logic [SBW-1:0]    o_side
);

    localparam int N = AW / 2;

    logic [AW-1:0]  r_v    [1:N];
    logic [AW-1:0]  r_res  [1:N];
    logic [SBW-1:0] r_sb   [1:N];
    logic [AW-1:0]  v_in   [0:N-1];
    logic [AW-1:0]  res_in [0:N-1];
    logic [SBW-1:0] sb_in  [0:N-1];

    // The first stage takes the radicand with an empty partial root.
    assign v_in[0]   = i_arg;
    assign res_in[0] = '0;
    assign sb_in[0]  = i_side;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            localparam logic [AW-1:0] BIT = AW'(1) << (AW - 2 - 2 * g);
            logic [AW-1:0] trial;

            if (g > 0) begin : g_link
                assign v_in[g]   = r_v[g];
                assign res_in[g] = r_res[g];
                assign sb_in[g]  = r_sb[g];
            end

            assign trial = res_in[g] + BIT;

            // Subtract the trial value when it fits and set this root bit.
            always_ff @(posedge i_clk) begin
                if (v_in[g] >= trial) begin
                    r_v[g+1]   <= v_in[g] - trial;
                    r_res[g+1] <= (res_in[g] >> 1) + BIT;
                end else begin
                    r_v[g+1]   <= v_in[g];
                    r_res[g+1] <= res_in[g] >> 1;
                end
                r_sb[g+1] <= sb_in[g];
            end
        end
    endgenerate

    assign o_root = r_res[N][AW/2-1:0];
    assign o_side = r_sb[N];

endmodule

>>> hdl/ibdw_axis.sv
// One-axis kernel gain pipeline: offset, scaling, radicand, root, numerator, gain.
// Depends on ibdw_pkg and ibdw_sqrt.
module ibdw_axis
    import ibdw_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic signed [COORD_W-1:0] i_cloud,
    input  logic signed [COORD_W-1:0] i_grid,
    input  logic [INV_W-1:0]          i_inv,
    output logic [GAIN_W-1:0]         o_gain
);

    localparam int RW  = FRAC_BITS + 2;      // r up to 2.0
    localparam int MW  = 2 * RW;
    localparam int XW  = 2 * FRAC_BITS + 6;  // radicand terms before clamping
    localparam int AW  = 2 * FRAC_BITS + 2;  // radicand, at most 2.0 squared scale
    localparam int SW  = AW / 2;
    localparam int NW  = FRAC_BITS + 3;      // eight times the kernel value
    localparam int SBW = RW + 2;
    localparam int PW  = 2 * INV_W;

    localparam logic [RW-1:0]  ONE    = RW'(1) << FRAC_BITS;
    localparam logic [PW-1:0]  TWO_P  = PW'(1) << (FRAC_BITS + 1);
    localparam logic [XW-1:0]  SQ     = XW'(1) << (2 * FRAC_BITS);
    localparam logic [NW:0]    ONE_N  = (NW + 1)'(1) << FRAC_BITS;

    logic signed [COORD_W:0] diff;
    logic [INV_W-1:0]        r_d;
    logic [PW-1:0]           r_p;
    logic [PW-1:0]           rsh;
    logic [RW-1:0]           rn;
    logic                    inner;
    logic [RW-1:0]           r_r3;
    logic                    r_inner3;
    logic                    r_big3;
    logic [MW-1:0]           r_m3;
    logic [XW-1:0]           arg_in;
    logic [XW-1:0]           pos;
    logic [XW-1:0]           neg;
    logic [XW-1:0]           arg_x;
    logic [AW-1:0]           r_arg4;
    logic [SBW-1:0]          r_sb4;
    logic [SW-1:0]           root;
    logic [SBW-1:0]          sb5;
    logic [RW-1:0]           r5;
    logic [NW:0]             t_in;
    logic [NW:0]             t_out;
    logic [NW:0]             s_ext;
    logic [NW-1:0]           num;
    logic [NW-1:0]           r_num5;
    logic [NW+INV_W-1:0]     r_g6;

    // Absolute offset, exact in 32 unsigned bits.
    assign diff = {i_grid[COORD_W-1], i_grid} - {i_cloud[COORD_W-1], i_cloud};

    always_ff @(posedge i_clk) begin
        r_d <= diff[COORD_W] ? INV_W'(-diff) : diff[INV_W-1:0];
    end

    // Scale the offset by the inverse spacing.
    always_ff @(posedge i_clk) begin
        r_p <= PW'(r_d) * PW'(i_inv);
    end

    // Branch choice and the one product the radicand needs.
    assign rsh   = r_p >> FRAC_BITS;
    assign rn    = rsh[RW-1:0];
    assign inner = (rn <= ONE);

    always_ff @(posedge i_clk) begin
        r_r3     <= rn;
        r_inner3 <= inner;
        r_big3   <= (rsh > TWO_P);
        r_m3     <= MW'(rn) * MW'(inner ? (ONE - rn) : rn);
    end

    // Radicand: inner 1 + 4r(1-r), outer 12r - 7 - 4r^2 clamped at zero.
    assign arg_in = SQ + (XW'(r_m3) << 2);
    assign pos    = (XW'(r_r3) * XW'(12)) << FRAC_BITS;
    assign neg    = (SQ * XW'(7)) + (XW'(r_m3) << 2);
    assign arg_x  = r_inner3 ? arg_in : ((pos > neg) ? (pos - neg) : '0);

    always_ff @(posedge i_clk) begin
        r_arg4 <= arg_x[AW-1:0];
        r_sb4  <= {r_r3, r_inner3, r_big3};
    end

    ibdw_sqrt #(
        .AW  (AW),
        .SBW (SBW)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_arg  (r_arg4),
        .i_side (r_sb4),
        .o_root (root),
        .o_side (sb5)
    );

    // Numerator: eight times the kernel value, zero beyond two.
    assign r5    = sb5[SBW-1:2];
    assign s_ext = (NW + 1)'(root);
    assign t_in  = (ONE_N * (NW + 1)'(3)) - ((NW + 1)'(r5) << 1) + s_ext;
    assign t_out = (ONE_N * (NW + 1)'(5)) - ((NW + 1)'(r5) << 1);

    always_comb begin
        if (sb5[0]) begin
            num = '0;
        end else if (sb5[1]) begin
            num = t_in[NW-1:0];
        end else if (t_out > s_ext) begin
            num = NW'(t_out - s_ext);
        end else begin
            num = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num5 <= num;
    end

    // Gain: kernel value times inverse spacing.
    always_ff @(posedge i_clk) begin
        r_g6 <= (NW + INV_W)'(r_num5) * (NW + INV_W)'(i_inv);
    end

    assign o_gain = GAIN_W'(r_g6 >> NW);

endmodule

>>> hdl/ibdw_weight.sv
// Three-way product of the axis gains, rescaled to Q24.24 and saturated.
// Depends on ibdw_pkg.
module ibdw_weight
    import ibdw_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic [GAIN_W-1:0] i_gx,
    input  logic [GAIN_W-1:0] i_gy,
    input  logic [GAIN_W-1:0] i_gz,
    output t_ibdw_out         o_out
);

    localparam int K  = 3 * FRAC_BITS - 24;
    localparam int HW = 2 * GAIN_W;
    localparam int FW = 3 * GAIN_W;

    logic [HW-1:0]  r_pxy;
    logic [GAIN_W-1:0] r_gz;
    logic [HW-1:0]  r_lo;
    logic [HW-1:0]  r_hi;
    logic [FW-1:0]  full;
    logic [FW-1:0]  shifted;
    t_ibdw_out      r_out;

    // First product: x times y.
    always_ff @(posedge i_clk) begin
        r_pxy <= HW'(i_gx) * HW'(i_gy);
        r_gz  <= i_gz;
    end

    // Second product split into two 32 by 32 partial products.
    always_ff @(posedge i_clk) begin
        r_lo <= HW'(r_pxy[GAIN_W-1:0]) * HW'(r_gz);
        r_hi <= HW'(r_pxy[HW-1:GAIN_W]) * HW'(r_gz);
    end

    // Merge, rescale and clamp.
    assign full    = (FW'(r_hi) << GAIN_W) + FW'(r_lo);
    assign shifted = full >> K;

    always_ff @(posedge i_clk) begin
        if (|shifted[FW-1:WEIGHT_W]) begin
            r_out.weight_value <= '1;
            r_out.saturated    <= 1'b1;
        end else begin
            r_out.weight_value <= shifted[WEIGHT_W-1:0];
            r_out.saturated    <= 1'b0;
        end
    end

    assign o_out = r_out;

endmodule

>>> hdl/ib_delta_weight_3d.sv
// Top level of the immersed-boundary delta weight block: config registers, valid
// pipeline, three axis pipelines, weight product. Depends on ibdw_pkg, ibdw_axis, ibdw_weight.
//
//  Channel  | Handshake                     | Payload
//  ---------+-------------------------------+---------------------------------
//  input    | start, busy (always low)      | i_in  (t_ibdw_in)
//  result   | o_done strobe, one cycle      | o_out (t_ibdw_out)
//  config   | i_cfg_valid, o_cfg_ready      | i_cfg_index, i_cfg_data
//
// One item is accepted every cycle. The pipeline depth is set by the square root,
// one root bit per stage, plus the offset, product and clamp stages around it.
// Reset clears the valid pipeline and loads 20.0 into each inverse spacing.
// The receiver cannot stall, so the pipeline never holds and busy stays low.
module ib_delta_weight_3d
    import ibdw_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_ibdw_in             i_in,
    output logic                 o_done,
    output t_ibdw_out            o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [INV_W-1:0]     i_cfg_data
);

    localparam int LAT = FRAC_BITS + 10;
    localparam logic [INV_W-1:0] INV_RST = INV_W'(64'(INV_RESET_INT) << FRAC_BITS);

    logic [INV_W-1:0]  r_inv_x;
    logic [INV_W-1:0]  r_inv_y;
    logic [INV_W-1:0]  r_inv_z;
    logic [LAT-1:0]    r_vld;
    logic [GAIN_W-1:0] gx;
    logic [GAIN_W-1:0] gy;
    logic [GAIN_W-1:0] gz;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_x <= INV_RST;
            r_inv_y <= INV_RST;
            r_inv_z <= INV_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INV_X: r_inv_x <= i_cfg_data;
                CFG_INV_Y: r_inv_y <= i_cfg_data;
                CFG_INV_Z: r_inv_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits travel down the pipeline with each transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    assign o_done = r_vld[LAT-1];

    ibdw_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
        .i_clk   (i_clk),
        .i_cloud (i_in.cloud_x),
        .i_grid  (i_in.grid_x),
        .i_inv   (r_inv_x),
        .o_gain  (gx)
    );

    ibdw_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
        .i_clk   (i_clk),
        .i_cloud (i_in.cloud_y),
        .i_grid  (i_in.grid_y),
        .i_inv   (r_inv_y),
        .o_gain  (gy)
    );

    ibdw_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
        .i_clk   (i_clk),
        .i_cloud (i_in.cloud_z),
        .i_grid  (i_in.grid_z),
        .i_inv   (r_inv_z),
        .o_gain  (gz)
    );

    ibdw_weight #(.FRAC_BITS(FRAC_BITS)) u_weight (
        .i_clk (i_clk),
        .i_gx  (gx),
        .i_gy  (gy),
        .i_gz  (gz),
        .o_out (o_out)
    );

endmodule
